// ===== hw/rtl/dssb_pkg.sv =====
// ----------------------------------------------------------------------------
// dssb_pkg
// Shared types, codes and helpers for the dual stack shared buffer.
// ----------------------------------------------------------------------------
package dssb_pkg;

  // Store geometry.
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Operation codes.
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_DUMP = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Stack selection.
  localparam logic SEL_LOWER = 1'b0;
  localparam logic SEL_UPPER = 1'b1;

  // One input transaction.
  typedef struct packed {
    logic [1:0]               kind;
    logic                     stack_select;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic signed [DATA_W-1:0] data_value;
    logic [1:0]               status;
    logic                     last_of_run;
  } out_item_t;

  // Store entry of position pos (0 is the bottom) of the selected stack.
  // The upper stack counts down from the top entry.
  function automatic logic [ADDR_W-1:0] slot_of(input logic sel,
                                                input logic [ADDR_W-1:0] pos);
    logic [ADDR_W-1:0] top_idx;
    top_idx = ADDR_W'(DEPTH - 1);
    if (sel == SEL_UPPER) begin
      return top_idx - pos;
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/dssb_ram.sv =====
// ----------------------------------------------------------------------------
// dssb_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module dssb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/dual_stack_shared_buffer.sv =====
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer
// Two LIFO stacks in one shared word store, driven by push, pop and dump.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_item) carries one operation per
// transaction: push, pop or dump on the lower or the upper stack. The result
// channel (out_valid, out_stall, out_item) returns one result per push or pop
// and one result per entry for a dump, the last one marked by last_of_run.
// The block takes a new transaction only when it is idle; a waiting result in
// the output register does not hold off acceptance.
// Sequence: a push result is loaded into the output register from S_EXEC, a
// pop result from S_RDWAIT after the store read issued in S_EXEC. A dump goes
// on from S_EXEC through S_DUMPRD and S_RDWAIT once per entry, one result each.
// The block cannot take a new transaction until it is back in S_IDLE; the
// single read port of the store and its registered read set these steps.
// Stall on the result channel holds the output register and the sequencer
// waits for it to drain before loading the next result.
// Reset clears both stack counts and the sequencer; the store content is left
// as it is and is only read at entries that have been written.
// ----------------------------------------------------------------------------
module dual_stack_shared_buffer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dssb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dssb_pkg::out_item_t out_item
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_DUMPRD = 4'b0100,
    S_RDWAIT = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [dssb_pkg::CNT_W-1:0]      lower_r, lower_nxt;
  logic [dssb_pkg::CNT_W-1:0]      upper_r, upper_nxt;
  logic [dssb_pkg::ADDR_W-1:0]     pos_r, pos_nxt;
  dssb_pkg::in_item_t              item_r;
  dssb_pkg::out_item_t             out_item_r, emit_item;
  logic                            out_valid_r;

  logic                            ram_wr_en, ram_rd_en;
  logic [dssb_pkg::ADDR_W-1:0]     ram_wr_addr, ram_rd_addr;
  logic [dssb_pkg::DATA_W-1:0]     ram_rd_data;

  logic [dssb_pkg::CNT_W-1:0]      cur_cnt;
  logic [dssb_pkg::CNT_W:0]        total_cnt;
  logic                            full, empty, out_free, emit, is_last;
  logic [dssb_pkg::ADDR_W-1:0]     top_pos, last_pos;

  // Shared store; a write and a later read of the same entry are always
  // separated by a return through S_IDLE, so no forwarding is needed.
  dssb_ram #(
    .WIDTH(dssb_pkg::DATA_W),
    .DEPTH(dssb_pkg::DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(item_r.push_value),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Status of the selected stack.
  assign cur_cnt   = (item_r.stack_select == dssb_pkg::SEL_UPPER) ? upper_r : lower_r;
  assign total_cnt = {1'b0, lower_r} + {1'b0, upper_r};
  assign full      = (total_cnt >= (dssb_pkg::CNT_W + 1)'(dssb_pkg::DEPTH));
  assign empty     = (cur_cnt == '0);
  assign top_pos   = cur_cnt[dssb_pkg::ADDR_W-1:0];
  assign last_pos  = dssb_pkg::ADDR_W'(cur_cnt - 1'b1);
  assign is_last   = (item_r.kind == dssb_pkg::KIND_POP) || (pos_r == last_pos);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    lower_nxt   = lower_r;
    upper_nxt   = upper_r;
    pos_nxt     = pos_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = dssb_pkg::slot_of(item_r.stack_select, top_pos);
    ram_rd_en   = 1'b0;
    ram_rd_addr = dssb_pkg::slot_of(item_r.stack_select, pos_r);
    emit        = 1'b0;
    emit_item   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_r.kind)
          dssb_pkg::KIND_PUSH: begin
            if (out_free) begin
              emit                  = 1'b1;
              emit_item.last_of_run = 1'b1;
              state_nxt             = S_IDLE;
              if (full) begin
                emit_item.status = dssb_pkg::ST_FULL;
              end else begin
                emit_item.status = dssb_pkg::ST_OK;
                ram_wr_en        = 1'b1;
                if (item_r.stack_select == dssb_pkg::SEL_UPPER) begin
                  upper_nxt = upper_r + 1'b1;
                end else begin
                  lower_nxt = lower_r + 1'b1;
                end
              end
            end
          end
          dssb_pkg::KIND_POP, dssb_pkg::KIND_DUMP: begin
            if (empty) begin
              if (out_free) begin
                emit                  = 1'b1;
                emit_item.status      = dssb_pkg::ST_EMPTY;
                emit_item.last_of_run = 1'b1;
                state_nxt             = S_IDLE;
              end
            end else if (item_r.kind == dssb_pkg::KIND_POP) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = dssb_pkg::slot_of(item_r.stack_select, last_pos);
              state_nxt   = S_RDWAIT;
              if (item_r.stack_select == dssb_pkg::SEL_UPPER) begin
                upper_nxt = upper_r - 1'b1;
              end else begin
                lower_nxt = lower_r - 1'b1;
              end
            end else begin
              pos_nxt   = '0;
              state_nxt = S_DUMPRD;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DUMPRD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_RDWAIT;
      end
      S_RDWAIT: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_item.data_value  = $signed(ram_rd_data);
          emit_item.status      = dssb_pkg::ST_OK;
          emit_item.last_of_run = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            state_nxt = S_DUMPRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lower_r     <= '0;
      upper_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  // The two stacks never hold more words than the store has.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, lower_r} + {1'b0, upper_r}) <= (dssb_pkg::CNT_W + 1)'(dssb_pkg::DEPTH))
    else $error("stack counts exceed the store depth");

  // A store write happens only for a push that finds room.
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == S_EXEC) && !full)
    else $error("store written without room");

  // The store is never read and written in the same cycle.
  a_rd_wr_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr_en && ram_rd_en))
    else $error("store read and write overlap");

  // The final result of a run returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDWAIT) && emit && is_last |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after a run");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression bench for the dual stack shared buffer.
// ----------------------------------------------------------------------------
// Push, pop and dump operations are sent on the input channel. A shadow copy
// of both stacks works out the replies that each accepted transaction should
// produce. Every reply taken from the result channel is compared field by
// field with the oldest awaited one. Short directed sequences come first: the
// empty stacks, extreme values and the point where the two stacks meet. Then
// come a long output hold-off that backs the block up, and random traffic that
// swings between filling and draining. Both sides idle in random bursts,
// except the sender during the hold-off, and both in the closing stretch.
// ----------------------------------------------------------------------------
module tb;
  import dssb_pkg::*;

  // The one operation code that the block ignores.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] VAL_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_ONES = {DATA_W{1'b1}};
  localparam logic signed [DATA_W-1:0] VAL_ZERO = '0;

  localparam int CYCLE_LIMIT  = 250_000;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_CYCLES  = 60;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Shadow copy of the two stacks.
  logic signed [DATA_W-1:0] shadow_store [DEPTH];
  logic [CNT_W-1:0]         lower_depth = '0;
  logic [CNT_W-1:0]         upper_depth = '0;

  // Replies still to come, oldest first.
  out_item_t awaited_replies [$];
  out_item_t reply_want;

  // Idling controls, written by the test sequence only.
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  int hold_span   = 0;
  int hold_ticket = 0;

  // Receiver-side bookkeeping, owned by the receiver process.
  int hold_seen  = 0;
  int hold_left  = 0;
  int burst_left = 0;

  // Run statistics.
  int op_count [4];
  int replies_checked    = 0;
  int mismatch_count     = 0;
  int full_refusals      = 0;
  int empty_replies      = 0;
  int longest_dump       = 0;
  int input_stall_cycles = 0;
  int cycle_count        = 0;

  dual_stack_shared_buffer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Store entry of a stack position; the upper stack counts down from the top.
  function automatic logic [ADDR_W-1:0] stack_slot(logic sel, int pos);
    return (sel == SEL_UPPER) ? ADDR_W'(DEPTH - 1 - pos) : ADDR_W'(pos);
  endfunction

  // Apply one accepted operation to the shadow stacks and queue its replies.
  function automatic void apply_stack_op(in_item_t op);
    int        n;
    out_item_t reply;
    n = (op.stack_select == SEL_UPPER) ? int'(upper_depth) : int'(lower_depth);
    reply = '0;
    reply.last_of_run = 1'b1;
    case (op.kind)
      KIND_PUSH: begin
        if (int'(lower_depth) + int'(upper_depth) >= DEPTH) begin
          reply.status = ST_FULL;
          full_refusals++;
        end else begin
          shadow_store[stack_slot(op.stack_select, n)] = op.push_value;
          if (op.stack_select == SEL_UPPER) upper_depth = CNT_W'(n + 1);
          else lower_depth = CNT_W'(n + 1);
          reply.status = ST_OK;
        end
        awaited_replies.push_back(reply);
      end
      KIND_POP: begin
        if (n == 0) begin
          reply.status = ST_EMPTY;
          empty_replies++;
        end else begin
          reply.data_value = shadow_store[stack_slot(op.stack_select, n - 1)];
          reply.status     = ST_OK;
          if (op.stack_select == SEL_UPPER) upper_depth = CNT_W'(n - 1);
          else lower_depth = CNT_W'(n - 1);
        end
        awaited_replies.push_back(reply);
      end
      KIND_DUMP: begin
        if (n == 0) begin
          reply.status = ST_EMPTY;
          empty_replies++;
          awaited_replies.push_back(reply);
        end else begin
          // One reply per entry, bottom first, the top one marked as last.
          for (int i = 0; i < n; i++) begin
            reply.data_value  = shadow_store[stack_slot(op.stack_select, i)];
            reply.status      = ST_OK;
            reply.last_of_run = (i == n - 1);
            awaited_replies.push_back(reply);
          end
          if (n > longest_dump) longest_dump = n;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Mostly random words, with the extremes mixed in now and then.
  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return VAL_ZERO;
      3:       return VAL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction, wait until it is taken and then perhaps idle.
  task automatic send_op(logic [1:0] kind, logic sel, logic signed [DATA_W-1:0] value);
    in_item_t op;
    op.kind         = kind;
    op.stack_select = sel;
    op.push_value   = value;
    in_item  <= op;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_stack_op(op);
    op_count[kind]++;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic check_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("reply %0d: %s expected %0h, got %0h", replies_checked, field, want, got);
      end
    end
  endtask

  // Pops and dumps on empty stacks, and the ignored operation code.
  task automatic test_empty_stacks();
    send_op(KIND_POP,    SEL_LOWER, VAL_ONES);
    send_op(KIND_POP,    SEL_UPPER, VAL_ZERO);
    send_op(KIND_DUMP,   SEL_LOWER, VAL_ZERO);
    send_op(KIND_DUMP,   SEL_UPPER, VAL_ONES);
    send_op(KIND_UNUSED, SEL_LOWER, VAL_ONES);
    send_op(KIND_UNUSED, SEL_UPPER, VAL_ZERO);
  endtask

  // Extreme values through both stacks, read back by dump and by pop.
  task automatic test_extreme_values();
    send_op(KIND_PUSH, SEL_LOWER, VAL_MAX);
    send_op(KIND_PUSH, SEL_LOWER, VAL_MIN);
    send_op(KIND_PUSH, SEL_UPPER, VAL_ONES);
    send_op(KIND_PUSH, SEL_UPPER, VAL_ZERO);
    send_op(KIND_DUMP, SEL_LOWER, VAL_ONES);
    send_op(KIND_DUMP, SEL_UPPER, VAL_ZERO);
    send_op(KIND_POP,  SEL_LOWER, VAL_ZERO);
    send_op(KIND_POP,  SEL_UPPER, VAL_ONES);
    send_op(KIND_POP,  SEL_LOWER, VAL_MAX);
    send_op(KIND_POP,  SEL_UPPER, VAL_MIN);
    send_op(KIND_POP,  SEL_LOWER, VAL_ZERO);
  endtask

  // Fill the store from both ends until the stacks meet, then probe the edge.
  task automatic test_meeting_point();
    repeat (DEPTH) send_op(KIND_PUSH, 1'($urandom_range(0, 1)), random_word());
    send_op(KIND_PUSH, SEL_LOWER, random_word());
    send_op(KIND_PUSH, SEL_UPPER, random_word());
    send_op(KIND_DUMP, SEL_LOWER, random_word());
    send_op(KIND_DUMP, SEL_UPPER, random_word());
    send_op(KIND_POP,  SEL_LOWER, random_word());
    send_op(KIND_PUSH, SEL_UPPER, random_word());
    send_op(KIND_PUSH, SEL_LOWER, random_word());
  endtask

  // The receiver holds off for a long stretch while transactions keep coming.
  task automatic test_output_hold_off();
    tx_idle_on  = 1'b0;
    hold_span   = HOLD_CYCLES;
    hold_ticket = hold_ticket + 1;
    repeat (20) send_op(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)), random_word());
    tx_idle_on = 1'b1;
  endtask

  // Random traffic in tides that alternately favour pushes and pops.
  task automatic test_random_traffic(int n_ops);
    int         sent;
    int         tide_left;
    int         roll;
    bit         filling;
    logic [1:0] kind;
    sent      = 0;
    tide_left = 0;
    filling   = 1'b0;
    while (sent < n_ops) begin
      if (tide_left == 0) begin
        filling   = !filling;
        tide_left = $urandom_range(8, 24);
      end
      tide_left--;
      roll = $urandom_range(0, 99);
      if (roll < 4) kind = KIND_UNUSED;
      else if (roll < 16) kind = KIND_DUMP;
      else if ((roll < 70) == filling) kind = KIND_PUSH;
      else kind = KIND_POP;
      send_op(kind, 1'($urandom_range(0, 1)), random_word());
      if (kind != KIND_UNUSED) sent++;
    end
  endtask

  // Receiver: a requested long hold-off first, otherwise random stall bursts.
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = hold_span;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted reply with the oldest awaited one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) input_stall_cycles++;
      if (out_valid && !out_stall) begin
        replies_checked++;
        if (awaited_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("reply %0d arrived with none awaited: data %0h status %0d last %0b",
                     replies_checked, out_item.data_value, out_item.status,
                     out_item.last_of_run);
          end
        end else begin
          reply_want = awaited_replies.pop_front();
          check_field("data_value", reply_want.data_value, out_item.data_value);
          check_field("status", DATA_W'(reply_want.status), DATA_W'(out_item.status));
          check_field("last_of_run", DATA_W'(reply_want.last_of_run),
                      DATA_W'(out_item.last_of_run));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d replies still awaited", awaited_replies.size());
      $display("dual_stack_shared_buffer regression: fail");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stacks();
    test_extreme_values();
    test_meeting_point();
    test_output_hold_off();
    test_random_traffic(140);

    // Closing stretch with neither side idling.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(60);

    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pushes, %0d pops, %0d dumps and %0d ignored codes; %0d replies checked.",
             op_count[KIND_PUSH], op_count[KIND_POP], op_count[KIND_DUMP],
             op_count[KIND_UNUSED], replies_checked);
    $display("Saw %0d full refusals, %0d empty replies, a longest dump of %0d, %0d input stalls.",
             full_refusals, empty_replies, longest_dump, input_stall_cycles);
    if (mismatch_count == 0 && awaited_replies.size() == 0) begin
      $display("dual_stack_shared_buffer regression: pass");
    end else begin
      $display("%0d mismatches, %0d replies never arrived", mismatch_count,
               awaited_replies.size());
      $display("dual_stack_shared_buffer regression: fail");
    end
    $finish;
  end

endmodule
